// ----- sv/time_of_day_arithmetic_unit_assert.svh -----
// assertion macros for the time-of-day unit
`ifndef TIME_OF_DAY_ARITHMETIC_UNIT_ASSERT_SVH
`define TIME_OF_DAY_ARITHMETIC_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TODAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TODAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/todau_pkg.sv -----
package todau_pkg;

  localparam int unsigned SEC_W  = 17;
  localparam int unsigned DUR_W  = 18;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned CNT_W  = 31;

  localparam logic [SEC_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [SEC_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [SEC_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [HOUR_W-1:0] MAX_HOUR    = 5'd23;
  localparam logic [MIN_W-1:0]  MAX_MIN     = 6'd59;

  // day = 128 * 675, so the count is split into low 7 bits and a 675 remainder
  localparam int unsigned DAY_SHIFT = 7;
  localparam logic [25:0] RECIP_675 = 26'd50903317;  // ceil(2^35 / 675)
  localparam int unsigned RECIP_675_SH = 35;
  localparam logic [12:0] RECIP_225 = 13'd4661;      // ceil(2^20 / 225)
  localparam int unsigned RECIP_225_SH = 20;
  localparam logic [10:0] RECIP_15  = 11'd1093;      // ceil(2^14 / 15)
  localparam int unsigned RECIP_15_SH = 14;

  typedef enum logic [1:0] {
    OP_SEC_TO_TIME = 2'd0,
    OP_ADD_SEC     = 2'd1,
    OP_SUB_SEC     = 2'd2
  } op_t;

  // result fields that do not depend on the opcode
  typedef struct packed {
    logic             a_is_valid;
    logic [SEC_W-1:0] a_in_seconds;
    logic             a_equals_b;
    logic             a_before_b;
    logic             a_after_b;
    logic [DUR_W-1:0] duration;
  } side_t;

endpackage

// ----- sv/time_of_day_arithmetic_unit.sv -----
// an accepted request passes stages 1 to 7 in order, and stage 7 drives out_tvalid
// throughput: one request per cycle while the output is not stalled; the seven stages advance together
// a stalled output holds every stage, and in_tready falls with it
// reset (rst_n, synchronous, active low) clears the stage valid bits only
`include "time_of_day_arithmetic_unit_assert.svh"

module time_of_day_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // hour_a[4:0] minute_a[10:5] second_a[16:11] hour_b[21:17] minute_b[27:22]
  // second_b[33:28] seconds_count[64:34], zero fill to bit 71
  input  logic [71:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hour_out[4:0] minute_out[10:5] second_out[16:11] a_is_valid[17]
  // a_in_seconds[34:18] a_equals_b[35] a_before_b[36] a_after_b[37] duration[55:38]
  output logic [55:0] out_tdata
);

  localparam int unsigned SW = todau_pkg::SEC_W;

  logic       advance;
  logic [7:1] vld_r;

  assign advance   = !vld_r[7] || out_tready;
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[6:1], in_tvalid};
    end
  end

  // stage 1: unpack, times in seconds, A validity and equality, count quotient by 675
  logic [4:0]  ha, hb;
  logic [5:0]  ma, sa, mb, sb;
  logic [30:0] cnt;
  logic [23:0] cnt_hi;
  logic [49:0] quo_prod;
  logic [SW-1:0] asec_nxt, bsec_nxt;

  assign ha     = in_tdata[4:0];
  assign ma     = in_tdata[10:5];
  assign sa     = in_tdata[16:11];
  assign hb     = in_tdata[21:17];
  assign mb     = in_tdata[27:22];
  assign sb     = in_tdata[33:28];
  assign cnt    = in_tdata[64:34];
  assign cnt_hi = cnt[30:todau_pkg::DAY_SHIFT];

  assign quo_prod = {26'b0, cnt_hi} * {24'b0, todau_pkg::RECIP_675};
  assign asec_nxt = SW'(ha) * todau_pkg::SEC_PER_HOUR + SW'(ma) * todau_pkg::SEC_PER_MIN
                    + SW'(sa);
  assign bsec_nxt = SW'(hb) * todau_pkg::SEC_PER_HOUR + SW'(mb) * todau_pkg::SEC_PER_MIN
                    + SW'(sb);

  todau_pkg::op_t op1_r;
  logic [14:0]    quo1_r;
  logic [23:0]    cnt_hi1_r;
  logic [6:0]     cnt_lo1_r;
  logic [SW-1:0]  asec1_r, bsec1_r;
  logic           valid1_r, eq1_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      op1_r     <= todau_pkg::op_t'(in_tuser);
      quo1_r    <= quo_prod[49:todau_pkg::RECIP_675_SH];
      cnt_hi1_r <= cnt_hi;
      cnt_lo1_r <= cnt[todau_pkg::DAY_SHIFT-1:0];
      asec1_r   <= asec_nxt;
      bsec1_r   <= bsec_nxt;
      valid1_r  <= (ha <= todau_pkg::MAX_HOUR) && (ma <= todau_pkg::MAX_MIN)
                   && (sa <= todau_pkg::MAX_MIN);
      eq1_r     <= (ha == hb) && (ma == mb) && (sa == sb);
    end
  end

  // stage 2: count modulo a day, A reduced below a day, compare and duration
  logic [23:0]    rem675;
  logic [SW-1:0]  nr_nxt, ar_nxt;
  todau_pkg::side_t side2_nxt;

  assign rem675 = cnt_hi1_r - 24'({9'b0, quo1_r} * 24'd675);
  assign nr_nxt = {rem675[9:0], cnt_lo1_r};
  assign ar_nxt = (asec1_r >= todau_pkg::SEC_PER_DAY) ? asec1_r - todau_pkg::SEC_PER_DAY
                                                      : asec1_r;

  always_comb begin
    side2_nxt.a_is_valid   = valid1_r;
    side2_nxt.a_in_seconds = asec1_r;
    side2_nxt.a_equals_b   = eq1_r;
    side2_nxt.a_before_b   = asec1_r < bsec1_r;
    side2_nxt.a_after_b    = asec1_r > bsec1_r;
    side2_nxt.duration     = {1'b0, bsec1_r} - {1'b0, asec1_r};
    if (side2_nxt.a_after_b) begin
      side2_nxt.duration = side2_nxt.duration + {1'b0, todau_pkg::SEC_PER_DAY};
    end
  end

  todau_pkg::op_t    op2_r;
  logic [SW-1:0]     nr2_r, ar2_r;
  todau_pkg::side_t  side2_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      op2_r   <= op1_r;
      nr2_r   <= nr_nxt;
      ar2_r   <= ar_nxt;
      side2_r <= side2_nxt;
    end
  end

  // stage 3: time of day picked by the opcode, always below a day
  logic [SW:0]   sum_w, diff_w;
  logic [SW-1:0] t_nxt;

  assign sum_w  = {1'b0, ar2_r} + {1'b0, nr2_r};
  assign diff_w = {1'b0, ar2_r} + {1'b0, todau_pkg::SEC_PER_DAY} - {1'b0, nr2_r};

  always_comb begin
    case (op2_r)
      todau_pkg::OP_SEC_TO_TIME: t_nxt = nr2_r;
      todau_pkg::OP_ADD_SEC: begin
        if (sum_w >= {1'b0, todau_pkg::SEC_PER_DAY}) begin
          t_nxt = SW'(sum_w - {1'b0, todau_pkg::SEC_PER_DAY});
        end else begin
          t_nxt = SW'(sum_w);
        end
      end
      todau_pkg::OP_SUB_SEC: begin
        if (ar2_r >= nr2_r) begin
          t_nxt = ar2_r - nr2_r;
        end else begin
          t_nxt = SW'(diff_w);
        end
      end
      default: t_nxt = '0;
    endcase
  end

  logic [SW-1:0]    t3_r;
  todau_pkg::side_t side3_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      t3_r    <= t_nxt;
      side3_r <= side2_r;
    end
  end

  // stage 4: hour = (t / 16) / 225 by reciprocal, exact below a day
  logic [25:0] hour_prod;

  assign hour_prod = {13'b0, t3_r[SW-1:4]} * {13'b0, todau_pkg::RECIP_225};

  logic [SW-1:0]    t4_r;
  logic [4:0]       h4_r;
  todau_pkg::side_t side4_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      t4_r    <= t3_r;
      h4_r    <= hour_prod[todau_pkg::RECIP_225_SH+4:todau_pkg::RECIP_225_SH];
      side4_r <= side3_r;
    end
  end

  // stage 5: seconds left within the hour
  logic [SW-1:0] r1_w;

  assign r1_w = t4_r - SW'(h4_r) * todau_pkg::SEC_PER_HOUR;

  logic [4:0]       h5_r;
  logic [11:0]      r1_5_r;
  todau_pkg::side_t side5_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      h5_r    <= h4_r;
      r1_5_r  <= r1_w[11:0];
      side5_r <= side4_r;
    end
  end

  // stage 6: minute = (r1 / 4) / 15 by reciprocal
  logic [20:0] min_prod;

  assign min_prod = {11'b0, r1_5_r[11:2]} * {10'b0, todau_pkg::RECIP_15};

  logic [4:0]       h6_r;
  logic [5:0]       m6_r;
  logic [11:0]      r1_6_r;
  todau_pkg::side_t side6_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      h6_r    <= h5_r;
      m6_r    <= min_prod[todau_pkg::RECIP_15_SH+5:todau_pkg::RECIP_15_SH];
      r1_6_r  <= r1_5_r;
      side6_r <= side5_r;
    end
  end

  // stage 7: second, output register
  logic [11:0] s_w;

  assign s_w = r1_6_r - 12'({6'b0, m6_r} * 12'd60);

  logic [4:0]       h7_r;
  logic [5:0]       m7_r, s7_r;
  todau_pkg::side_t side7_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      h7_r    <= h6_r;
      m7_r    <= m6_r;
      s7_r    <= s_w[5:0];
      side7_r <= side6_r;
    end
  end

  assign out_tvalid = vld_r[7];
  assign out_tdata  = {side7_r.duration, side7_r.a_after_b, side7_r.a_before_b,
                       side7_r.a_equals_b, side7_r.a_in_seconds, side7_r.a_is_valid,
                       s7_r, m7_r, h7_r};

  `TODAU_ASSERT_NOW(a_time_in_range, out_tvalid,
    (h7_r <= todau_pkg::MAX_HOUR) && (m7_r <= todau_pkg::MAX_MIN)
    && (s7_r <= todau_pkg::MAX_MIN), "result time out of range")
  `TODAU_ASSERT_NOW(a_valid_below_day, out_tvalid && side7_r.a_is_valid,
    side7_r.a_in_seconds < todau_pkg::SEC_PER_DAY, "valid time not below a day")
  `TODAU_ASSERT_NOW(a_flags_exclusive, out_tvalid,
    $onehot0({side7_r.a_equals_b, side7_r.a_before_b, side7_r.a_after_b}),
    "compare flags not exclusive")
  `TODAU_ASSERT_NEXT(a_stall_holds_time, out_tvalid && !out_tready,
    out_tvalid && $stable(h7_r) && $stable(m7_r) && $stable(s7_r) && $stable(side7_r),
    "stalled result changed")

endmodule
